// ===== design/imconv_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the convolution block.
package imconv_pkg;

    // Storage geometry
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int MAX_KERNEL = 7;

    // Field widths
    localparam int COORD_W = 8;
    localparam int PIX_W   = 8;
    localparam int COEF_W  = 16;
    localparam int OUT_W   = 17;
    localparam int DIM_W   = 9;
    localparam int KSZ_W   = 3;

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 9;

    // Register reset values
    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(256);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(256);
    localparam logic [KSZ_W-1:0] KSIZE_RESET  = KSZ_W'(3);

    // Stream packing, lowest bit first
    localparam int COL_LSB   = 0;
    localparam int ROW_LSB   = COL_LSB + COORD_W;
    localparam int PIX_LSB   = ROW_LSB + COORD_W;
    localparam int COEF_LSB  = PIX_LSB + PIX_W;
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;

    // Memories
    localparam int IMG_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int IMG_AW    = $clog2(IMG_DEPTH);
    localparam int KER_DEPTH = MAX_KERNEL * MAX_KERNEL;
    localparam int KER_AW    = $clog2(KER_DEPTH);
    localparam int KIDX_W    = $clog2(MAX_KERNEL);

    // Arithmetic
    localparam int POS_W      = COORD_W + 2;
    localparam int PROD_W     = PIX_W + 1 + COEF_W;
    localparam int ACC_W      = 32;
    localparam int FRAC_BITS  = 12;
    localparam int ROUND_HALF = 2048;
    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    // Operation codes carried on tuser
    typedef enum logic [S_TUSER_W-1:0] {
        OP_STORE_PIXEL = 2'd0,
        OP_STORE_COEF  = 2'd1,
        OP_COMPUTE     = 2'd2
    } opcode_t;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_KERNEL_SIZE  = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TAPS,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic              in_ready;
        logic              tap_issue;
        logic [KIDX_W-1:0] tap_col;
        logic [KIDX_W-1:0] tap_row;
        logic              out_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic             pipe_busy;
        logic             out_free;
        logic [KSZ_W-1:0] ksize;
    } sts_t;

endpackage

// ===== design/imconv_ctrl.sv =====
// Sequencer for the convolution block: walks the kernel taps and hands off the result.
module imconv_ctrl (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic [imconv_pkg::S_TUSER_W-1:0] s_tuser,
    input  imconv_pkg::sts_t                 sts,
    output imconv_pkg::cmd_t                 cmd
);

    imconv_pkg::state_t state_reg, state_next;
    logic [imconv_pkg::KIDX_W-1:0] col_reg, col_next;
    logic [imconv_pkg::KIDX_W-1:0] row_reg, row_next;
    logic [imconv_pkg::KIDX_W-1:0] k_last;
    logic start;
    logic last_col;
    logic last_row;

    assign k_last   = imconv_pkg::KIDX_W'(sts.ksize - imconv_pkg::KSZ_W'(1));
    assign start    = s_tvalid && (state_reg == imconv_pkg::ST_IDLE)
                      && (s_tuser == imconv_pkg::OP_COMPUTE);
    assign last_col = (col_reg == k_last);
    assign last_row = (row_reg == k_last);

    // State and tap counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= imconv_pkg::ST_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
        end else begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            imconv_pkg::ST_IDLE: begin
                if (start) state_next = imconv_pkg::ST_TAPS;
            end
            imconv_pkg::ST_TAPS: begin
                if (last_col && last_row) state_next = imconv_pkg::ST_DRAIN;
            end
            imconv_pkg::ST_DRAIN: begin
                if (!sts.pipe_busy) state_next = imconv_pkg::ST_FINISH;
            end
            imconv_pkg::ST_FINISH: begin
                if (sts.out_free) state_next = imconv_pkg::ST_IDLE;
            end
        endcase
    end

    // Tap walk: column fastest, then row
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (start) begin
            col_next = '0;
            row_next = '0;
        end else if (state_reg == imconv_pkg::ST_TAPS) begin
            if (last_col) begin
                col_next = '0;
                if (!last_row) row_next = row_reg + imconv_pkg::KIDX_W'(1);
            end else begin
                col_next = col_reg + imconv_pkg::KIDX_W'(1);
            end
        end
    end

    // Outputs; nothing is taken in while reset is held
    always_comb begin
        cmd           = '0;
        cmd.in_ready  = (state_reg == imconv_pkg::ST_IDLE) && aresetn;
        cmd.tap_issue = (state_reg == imconv_pkg::ST_TAPS);
        cmd.tap_col   = col_reg;
        cmd.tap_row   = row_reg;
        cmd.out_load  = (state_reg == imconv_pkg::ST_FINISH) && sts.out_free;
    end

`ifndef NO_ASSERTIONS
    // New items only enter once the multiply-accumulate pipe is empty
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.in_ready |-> !sts.pipe_busy)
        else $error("input ready while taps still in flight");

    // Tap counters stay inside the kernel
    a_tap_in_kernel: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == imconv_pkg::ST_TAPS) |-> (col_reg <= k_last) && (row_reg <= k_last))
        else $error("tap counter beyond kernel size");

    // The sum is not taken while products are pending
    a_drain_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == imconv_pkg::ST_DRAIN) && sts.pipe_busy
        |=> (state_reg == imconv_pkg::ST_DRAIN))
        else $error("drain left with products pending");

    // A result waits while the output register is still held
    a_finish_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == imconv_pkg::ST_FINISH) && !sts.out_free
        |=> (state_reg == imconv_pkg::ST_FINISH))
        else $error("result dropped while output register full");
`endif

endmodule

// ===== design/imconv_dp.sv =====
// Datapath of the convolution block: stores, tap addressing, multiply-accumulate, output register.
module imconv_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    input  logic [imconv_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic [imconv_pkg::S_TUSER_W-1:0]    s_tuser,
    input  logic                                cfg_we,
    input  logic [imconv_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [imconv_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  imconv_pkg::cmd_t                    cmd,
    output imconv_pkg::sts_t                    sts,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic [imconv_pkg::M_TDATA_W-1:0]    m_tdata
);

    // Input fields
    logic [imconv_pkg::COORD_W-1:0]       in_col;
    logic [imconv_pkg::COORD_W-1:0]       in_row;
    logic [imconv_pkg::PIX_W-1:0]         in_pix;
    logic signed [imconv_pkg::COEF_W-1:0] in_coef;
    logic accept;

    // Configuration
    logic [imconv_pkg::DIM_W-1:0] width_reg;
    logic [imconv_pkg::DIM_W-1:0] height_reg;
    logic [imconv_pkg::KSZ_W-1:0] ksize_reg;
    logic [imconv_pkg::DIM_W-1:0] w_sat;
    logic [imconv_pkg::DIM_W-1:0] h_sat;
    logic [imconv_pkg::KSZ_W-1:0] k_sat;

    // Per-request snapshot
    logic [imconv_pkg::COORD_W-1:0] x_reg;
    logic [imconv_pkg::COORD_W-1:0] y_reg;
    logic [imconv_pkg::COORD_W-1:0] w_last_reg;
    logic [imconv_pkg::COORD_W-1:0] h_last_reg;
    logic [imconv_pkg::KIDX_W-1:0]  half_reg;
    logic [imconv_pkg::KSZ_W-1:0]   ksz_reg;

    // Tap addressing
    logic signed [imconv_pkg::POS_W-1:0] pos_x;
    logic signed [imconv_pkg::POS_W-1:0] pos_y;
    logic [imconv_pkg::COORD_W-1:0]      tap_x;
    logic [imconv_pkg::COORD_W-1:0]      tap_y;
    logic [imconv_pkg::IMG_AW-1:0]       img_raddr;
    logic [imconv_pkg::IMG_AW-1:0]       img_waddr;
    logic [imconv_pkg::KER_AW-1:0]       ker_raddr;
    logic [imconv_pkg::KER_AW-1:0]       ker_waddr;
    logic img_we;
    logic ker_we;

    // Memories
    logic [imconv_pkg::PIX_W-1:0]         img_mem [imconv_pkg::IMG_DEPTH];
    logic signed [imconv_pkg::COEF_W-1:0] ker_mem [imconv_pkg::KER_DEPTH];

    // Multiply-accumulate pipe
    logic [imconv_pkg::PIX_W-1:0]         pix_reg;
    logic signed [imconv_pkg::COEF_W-1:0] coef_reg;
    logic                                 rd_valid_reg;
    logic signed [imconv_pkg::PROD_W-1:0] prod_reg;
    logic                                 prod_valid_reg;
    logic signed [imconv_pkg::ACC_W-1:0]  acc_reg;

    // Result
    logic signed [imconv_pkg::ACC_W-1:0] acc_rnd;
    logic signed [imconv_pkg::ACC_W-1:0] acc_shift;
    logic [imconv_pkg::OUT_W-1:0]        result;
    logic [imconv_pkg::OUT_W-1:0]        out_data_reg;
    logic                                out_valid_reg;

    function automatic logic [imconv_pkg::COORD_W-1:0] clamp_pos(
        input logic signed [imconv_pkg::POS_W-1:0] p,
        input logic [imconv_pkg::COORD_W-1:0]      last
    );
        logic [imconv_pkg::COORD_W-1:0] r;
        if (p < 0) begin
            r = '0;
        end else if (p > $signed(imconv_pkg::POS_W'(last))) begin
            r = last;
        end else begin
            r = p[imconv_pkg::COORD_W-1:0];
        end
        return r;
    endfunction

    assign in_col  = s_tdata[imconv_pkg::COL_LSB +: imconv_pkg::COORD_W];
    assign in_row  = s_tdata[imconv_pkg::ROW_LSB +: imconv_pkg::COORD_W];
    assign in_pix  = s_tdata[imconv_pkg::PIX_LSB +: imconv_pkg::PIX_W];
    assign in_coef = $signed(s_tdata[imconv_pkg::COEF_LSB +: imconv_pkg::COEF_W]);
    assign accept  = s_tvalid && cmd.in_ready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= imconv_pkg::WIDTH_RESET;
            height_reg <= imconv_pkg::HEIGHT_RESET;
            ksize_reg  <= imconv_pkg::KSIZE_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                imconv_pkg::CFG_IMAGE_WIDTH:  width_reg  <= cfg_wdata;
                imconv_pkg::CFG_IMAGE_HEIGHT: height_reg <= cfg_wdata;
                imconv_pkg::CFG_KERNEL_SIZE:  ksize_reg  <= cfg_wdata[imconv_pkg::KSZ_W-1:0];
                default: ;
            endcase
        end
    end

    // Dimensions saturated into their legal ranges
    always_comb begin
        if (width_reg == '0) begin
            w_sat = imconv_pkg::DIM_W'(1);
        end else if (32'(width_reg) > imconv_pkg::MAX_WIDTH) begin
            w_sat = imconv_pkg::DIM_W'(imconv_pkg::MAX_WIDTH);
        end else begin
            w_sat = width_reg;
        end
        if (height_reg == '0) begin
            h_sat = imconv_pkg::DIM_W'(1);
        end else if (32'(height_reg) > imconv_pkg::MAX_HEIGHT) begin
            h_sat = imconv_pkg::DIM_W'(imconv_pkg::MAX_HEIGHT);
        end else begin
            h_sat = height_reg;
        end
        if (ksize_reg == '0) begin
            k_sat = imconv_pkg::KSZ_W'(1);
        end else if (32'(ksize_reg) > imconv_pkg::MAX_KERNEL) begin
            k_sat = imconv_pkg::KSZ_W'(imconv_pkg::MAX_KERNEL);
        end else begin
            k_sat = ksize_reg;
        end
    end

    // Capture position and geometry when a compute request is accepted
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ksz_reg <= imconv_pkg::KSIZE_RESET;
        end else if (accept && (s_tuser == imconv_pkg::OP_COMPUTE)) begin
            ksz_reg <= k_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && (s_tuser == imconv_pkg::OP_COMPUTE)) begin
            x_reg      <= in_col;
            y_reg      <= in_row;
            w_last_reg <= imconv_pkg::COORD_W'(w_sat - imconv_pkg::DIM_W'(1));
            h_last_reg <= imconv_pkg::COORD_W'(h_sat - imconv_pkg::DIM_W'(1));
            half_reg   <= imconv_pkg::KIDX_W'(k_sat >> 1);
        end
    end

    // Tap position, clamped into the image
    assign pos_x = $signed(imconv_pkg::POS_W'(x_reg)) - $signed(imconv_pkg::POS_W'(half_reg))
                   + $signed(imconv_pkg::POS_W'(cmd.tap_col));
    assign pos_y = $signed(imconv_pkg::POS_W'(y_reg)) - $signed(imconv_pkg::POS_W'(half_reg))
                   + $signed(imconv_pkg::POS_W'(cmd.tap_row));
    assign tap_x = clamp_pos(pos_x, w_last_reg);
    assign tap_y = clamp_pos(pos_y, h_last_reg);

    assign img_raddr = imconv_pkg::IMG_AW'(32'(tap_y) * imconv_pkg::MAX_WIDTH + 32'(tap_x));
    assign ker_raddr = imconv_pkg::KER_AW'(32'(cmd.tap_row) * imconv_pkg::MAX_KERNEL
                                           + 32'(cmd.tap_col));

    // Store decode; stores outside the arrays are dropped
    assign img_we    = accept && (s_tuser == imconv_pkg::OP_STORE_PIXEL)
                       && (32'(in_col) < imconv_pkg::MAX_WIDTH)
                       && (32'(in_row) < imconv_pkg::MAX_HEIGHT);
    assign ker_we    = accept && (s_tuser == imconv_pkg::OP_STORE_COEF)
                       && (32'(in_col) < imconv_pkg::MAX_KERNEL)
                       && (32'(in_row) < imconv_pkg::MAX_KERNEL);
    assign img_waddr = imconv_pkg::IMG_AW'(32'(in_row) * imconv_pkg::MAX_WIDTH + 32'(in_col));
    assign ker_waddr = imconv_pkg::KER_AW'(32'(in_row) * imconv_pkg::MAX_KERNEL + 32'(in_col));

    // Image memory
    always_ff @(posedge aclk) begin
        if (img_we) img_mem[img_waddr] <= in_pix;
        if (cmd.tap_issue) pix_reg <= img_mem[img_raddr];
    end

    // Kernel memory
    always_ff @(posedge aclk) begin
        if (ker_we) ker_mem[ker_waddr] <= in_coef;
        if (cmd.tap_issue) coef_reg <= ker_mem[ker_raddr];
    end

    // Multiply, then accumulate
    always_ff @(posedge aclk) begin
        prod_reg <= $signed({1'b0, pix_reg}) * coef_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg   <= cmd.tap_issue;
            prod_valid_reg <= rd_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && (s_tuser == imconv_pkg::OP_COMPUTE)) begin
            acc_reg <= '0;
        end else if (prod_valid_reg) begin
            acc_reg <= acc_reg + imconv_pkg::ACC_W'(prod_reg);
        end
    end

    // Round half up from Q.12, zero below, saturate on top
    assign acc_rnd   = acc_reg + imconv_pkg::ACC_W'(imconv_pkg::ROUND_HALF);
    assign acc_shift = acc_rnd >>> imconv_pkg::FRAC_BITS;

    always_comb begin
        if (acc_reg < 0) begin
            result = '0;
        end else if (acc_shift > $signed(imconv_pkg::ACC_W'(imconv_pkg::OUT_MAX))) begin
            result = imconv_pkg::OUT_MAX;
        end else begin
            result = acc_shift[imconv_pkg::OUT_W-1:0];
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) out_data_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = imconv_pkg::M_TDATA_W'(out_data_reg);

    // Status
    assign sts.pipe_busy = rd_valid_reg || prod_valid_reg;
    assign sts.out_free  = !out_valid_reg || m_tready;
    assign sts.ksize     = ksz_reg;

endmodule

// ===== design/image_convolution_clamped_edges.sv =====
// Top level of the 2D convolution block with replicated image borders.
// Pixel and coefficient stores are accepted back to back, also while a result waits in the
// output register. A compute request for a kernel of side C runs in order through the
// acceptance of the request, the C*C window taps read one per cycle from the single-read-port
// image and kernel memories into one multiply-accumulate unit, the emptying of the read and
// product registers into the accumulator, and the rounding and loading of the result. That
// last step stretches while an earlier result still waits in the output register. No new
// item is accepted while a compute runs or while reset is held.
// The memories have no reset; reading a pixel or coefficient never written gives an
// undefined sum.
module image_convolution_clamped_edges (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input channel
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // tdata: col[7:0], row[15:8], pixel_value[23:16], coefficient[39:24]
    input  logic [imconv_pkg::S_TDATA_W-1:0]    s_tdata,
    // tuser: opcode[1:0]
    input  logic [imconv_pkg::S_TUSER_W-1:0]    s_tuser,
    // Result channel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // tdata: filtered_value[16:0], zero filled above
    output logic [imconv_pkg::M_TDATA_W-1:0]    m_tdata,
    // Configuration writes: 0 image_width, 1 image_height, 2 kernel_size
    input  logic                                cfg_we,
    input  logic [imconv_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [imconv_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    imconv_pkg::cmd_t cmd;
    imconv_pkg::sts_t sts;

    assign s_tready = cmd.in_ready;

    imconv_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    imconv_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

endmodule
